@@ rtl/core/ost_pkg.sv @@
// Shared types and constants for the ordered sequence table.
// Used by the cell, the pick tree and the top level; depends on nothing.
package ost_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int VALUE_BITS_DEF = 32;

    localparam int CMD_BITS    = 3;
    localparam int STATUS_BITS = 2;
    localparam int ITEM_BITS   = 32;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_INS_AT   = 3'd0,
        CMD_INS_SORT = 3'd1,
        CMD_ERASE    = 3'd2,
        CMD_REMOVE   = 3'd3,
        CMD_GET      = 3'd4,
        CMD_SET      = 3'd5,
        CMD_FIND     = 3'd6
    } cmd_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_POS   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INSERT,
        OP_ERASE,
        OP_WRITE,
        OP_MARK,
        OP_SWAP
    } cell_op_t;

    typedef enum logic [1:0] {
        PICK_MATCH,
        PICK_NOT_LESS,
        PICK_AT_POS,
        PICK_DEAD
    } pick_t;

    typedef struct packed {
        cell_op_t op;
        pick_t    pick;
        logic     phase;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_COMPACT,
        S_SEARCH,
        S_FINISH
    } state_t;

endpackage

@@ rtl/core/ost_cell.sv @@
// One storage cell of the sequence chain: holds one entry and a removal mark.
// Trades values with its two neighbors; depends on ost_pkg.
module ost_cell
    import ost_pkg::*;
#(
    parameter int VB  = VALUE_BITS_DEF,
    parameter int CW  = 7,
    parameter int IDX = 0
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  cell_ctrl_t    ctrl,
    input  logic [CW-1:0] pos,
    input  logic [CW-1:0] fill,
    input  logic [VB-1:0] wr_value,
    input  logic [VB-1:0] left_value,
    input  logic          left_dead,
    input  logic [VB-1:0] right_value,
    input  logic          right_dead,
    output logic [VB-1:0] value,
    output logic          dead,
    output logic          flag
);

    localparam logic ODD = 1'(IDX % 2);

    logic [VB-1:0] value_reg, value_next;
    logic          dead_reg, dead_next;
    logic          in_use;
    logic          at_pos;
    logic          is_left;

    assign in_use  = CW'(IDX) < fill;
    assign at_pos  = CW'(IDX) == pos;
    assign is_left = ODD == ctrl.phase;

    always_comb
    begin
        value_next = value_reg;
        dead_next  = dead_reg;
        unique case (ctrl.op)
            OP_INSERT:
            begin
                if (at_pos)
                    value_next = wr_value;
                else if (CW'(IDX) > pos)
                    value_next = left_value;
            end
            OP_ERASE:
            begin
                if (CW'(IDX) >= pos)
                    value_next = right_value;
            end
            OP_WRITE:
            begin
                if (at_pos)
                    value_next = wr_value;
            end
            OP_MARK:
            begin
                dead_next = !in_use || (value_reg == wr_value);
            end
            OP_SWAP:
            begin
                if (is_left)
                begin
                    if (dead_reg && !right_dead)
                    begin
                        value_next = right_value;
                        dead_next  = 1'b0;
                    end
                end
                else if (!dead_reg && left_dead)
                begin
                    dead_next = 1'b1;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_comb
    begin
        unique case (ctrl.pick)
            PICK_MATCH:    flag = in_use && (value_reg == wr_value);
            PICK_NOT_LESS: flag = in_use && !(value_reg < wr_value);
            PICK_AT_POS:   flag = at_pos;
            PICK_DEAD:     flag = dead_reg;
            default:       flag = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dead_reg <= 1'b0;
        else
            dead_reg <= dead_next;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign dead  = dead_reg;

endmodule

@@ rtl/core/ost_pick_tree.sv @@
// Registered priority tree: finds the lowest flagged cell and its value.
// One register level per tree level; depends on ost_pkg.
module ost_pick_tree
    import ost_pkg::*;
#(
    parameter int N  = DEPTH_DEF,
    parameter int VB = VALUE_BITS_DEF,
    parameter int IW = $clog2(DEPTH_DEF)
)
(
    input  logic          clk,
    input  logic          flags  [N],
    input  logic [VB-1:0] values [N],
    output logic          found,
    output logic [IW-1:0] index,
    output logic [VB-1:0] value
);

    localparam int P2 = 1 << IW;

    logic          leaf_f [P2];
    logic [VB-1:0] leaf_v [P2];
    logic          node_f [1:P2-1];
    logic [IW-1:0] node_i [1:P2-1];
    logic [VB-1:0] node_v [1:P2-1];

    for (genvar i = 0; i < P2; i++)
    begin : g_leaf
        if (i < N)
        begin : g_real
            assign leaf_f[i] = flags[i];
            assign leaf_v[i] = values[i];
        end
        else
        begin : g_pad
            assign leaf_f[i] = 1'b0;
            assign leaf_v[i] = '0;
        end
    end

    for (genvar n = 1; n < P2; n++)
    begin : g_node
        logic          lf, rf;
        logic [IW-1:0] li, ri;
        logic [VB-1:0] lv, rv;

        if (2 * n >= P2)
        begin : g_from_leaf
            assign lf = leaf_f[2*n-P2];
            assign rf = leaf_f[2*n+1-P2];
            assign li = IW'(2*n-P2);
            assign ri = IW'(2*n+1-P2);
            assign lv = leaf_v[2*n-P2];
            assign rv = leaf_v[2*n+1-P2];
        end
        else
        begin : g_from_node
            assign lf = node_f[2*n];
            assign rf = node_f[2*n+1];
            assign li = node_i[2*n];
            assign ri = node_i[2*n+1];
            assign lv = node_v[2*n];
            assign rv = node_v[2*n+1];
        end

        always_ff @(posedge clk)
        begin
            node_f[n] <= lf | rf;
            node_i[n] <= lf ? li : ri;
            node_v[n] <= lf ? lv : rv;
        end
    end

    assign found = node_f[1];
    assign index = node_i[1];
    assign value = node_v[1];

endmodule

@@ rtl/core/ordered_sequence_table.sv @@
// Top level of the ordered sequence table: command sequencer, cell chain, pick tree.
// Depends on ost_pkg, ost_cell and ost_pick_tree.
//
// channel  | dir | beat contents
// s_axis   | in  | command, position, item_value
// m_axis   | out | status, result_index, read_value, entry_count, is_empty
//
// Insert at, erase, set, rejected commands: accept, then apply.
// Insert sorted, get, find: accept, decide, search over the pick tree levels, finish.
// Remove all: accept and mark, DEPTH odd-even compaction phases in the cell chain,
// then the pick tree search and finish.
// Reset empties the sequence at once; no clearing pass.
// A held result stalls only the apply cycle; a new beat is taken while it waits.
module ordered_sequence_table
    import ost_pkg::*;
#(
    parameter  int DEPTH      = DEPTH_DEF,
    parameter  int VALUE_BITS = VALUE_BITS_DEF,
    localparam int CW         = $clog2(DEPTH + 1),
    localparam int IN_BITS    = CMD_BITS + CW + ITEM_BITS,
    localparam int IN_W       = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS   = STATUS_BITS + CW + ITEM_BITS + CW + 1,
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // command, position, item_value
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // status, result_index, read_value, entry_count, is_empty
    output logic [OUT_W-1:0] m_axis_tdata
);

    localparam int IW       = $clog2(DEPTH);
    localparam int VB       = VALUE_BITS;

    state_t               state_reg, state_next;
    logic [CMD_BITS-1:0]  cmd_reg;
    logic [CW-1:0]        pos_reg;
    logic [VB-1:0]        val_reg;
    logic [CW-1:0]        fill_reg, fill_next;
    logic [CW-1:0]        cnt_reg, cnt_next;

    logic                 out_valid_reg;
    logic [STATUS_BITS-1:0] out_status_reg, out_status_next;
    logic [CW-1:0]        out_index_reg, out_index_next;
    logic [ITEM_BITS-1:0] out_rdata_reg, out_rdata_next;
    logic [CW-1:0]        out_count_reg;
    logic                 out_load;
    logic                 out_free;
    logic                 in_accept;

    cell_ctrl_t           cell_ctrl;
    logic [CW-1:0]        cell_pos;
    logic [VB-1:0]        cell_value [DEPTH];
    logic                 cell_dead  [DEPTH];
    logic                 cell_flag  [DEPTH];

    logic                 root_found;
    logic [IW-1:0]        root_index;
    logic [VB-1:0]        root_value;
    logic [CW-1:0]        sort_at;
    logic [CW-1:0]        new_fill;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign sort_at   = root_found ? CW'(root_index) : fill_reg;
    assign new_fill  = root_found ? CW'(root_index) : CW'(DEPTH);

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [VB-1:0] lv, rv;
        logic          ld, rd;

        if (i == 0)
        begin : g_first
            assign lv = '0;
            assign ld = 1'b0;
        end
        else
        begin : g_mid_l
            assign lv = cell_value[i-1];
            assign ld = cell_dead[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign rv = '0;
            assign rd = 1'b1;
        end
        else
        begin : g_mid_r
            assign rv = cell_value[i+1];
            assign rd = cell_dead[i+1];
        end

        ost_cell #(
            .VB  (VB),
            .CW  (CW),
            .IDX (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (cell_ctrl),
            .pos         (cell_pos),
            .fill        (fill_reg),
            .wr_value    (val_reg),
            .left_value  (lv),
            .left_dead   (ld),
            .right_value (rv),
            .right_dead  (rd),
            .value       (cell_value[i]),
            .dead        (cell_dead[i]),
            .flag        (cell_flag[i])
        );
    end

    ost_pick_tree #(
        .N  (DEPTH),
        .VB (VB),
        .IW (IW)
    ) u_pick_tree (
        .clk    (clk),
        .flags  (cell_flag),
        .values (cell_value),
        .found  (root_found),
        .index  (root_index),
        .value  (root_value)
    );

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        cnt_next        = cnt_reg;
        out_load        = 1'b0;
        out_status_next = ST_OK;
        out_index_next  = '0;
        out_rdata_next  = '0;
        s_axis_tready   = 1'b0;
        cell_pos        = pos_reg;
        cell_ctrl.op    = OP_HOLD;
        cell_ctrl.phase = cnt_reg[0];

        unique case (cmd_reg)
            CMD_REMOVE:   cell_ctrl.pick = PICK_DEAD;
            CMD_INS_SORT: cell_ctrl.pick = PICK_NOT_LESS;
            CMD_GET:      cell_ctrl.pick = PICK_AT_POS;
            default:      cell_ctrl.pick = PICK_MATCH;
        endcase

        unique case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                unique case (cmd_reg)
                    CMD_INS_AT:
                    begin
                        if (out_free)
                        begin
                            out_load   = 1'b1;
                            state_next = S_IDLE;
                            if (pos_reg > fill_reg)
                                out_status_next = ST_BAD_POS;
                            else if (fill_reg == CW'(DEPTH))
                                out_status_next = ST_FULL;
                            else
                            begin
                                cell_ctrl.op   = OP_INSERT;
                                fill_next      = fill_reg + CW'(1);
                                out_index_next = pos_reg;
                            end
                        end
                    end
                    CMD_INS_SORT:
                    begin
                        if (fill_reg == CW'(DEPTH))
                        begin
                            if (out_free)
                            begin
                                out_load        = 1'b1;
                                out_status_next = ST_FULL;
                                state_next      = S_IDLE;
                            end
                        end
                        else
                        begin
                            cnt_next   = CW'(IW - 1);
                            state_next = S_SEARCH;
                        end
                    end
                    CMD_ERASE:
                    begin
                        if (out_free)
                        begin
                            out_load   = 1'b1;
                            state_next = S_IDLE;
                            if (pos_reg >= fill_reg)
                                out_status_next = ST_BAD_POS;
                            else
                            begin
                                cell_ctrl.op = OP_ERASE;
                                fill_next    = fill_reg - CW'(1);
                            end
                        end
                    end
                    CMD_REMOVE:
                    begin
                        cell_ctrl.op = OP_MARK;
                        cnt_next     = CW'(DEPTH - 1);
                        state_next   = S_COMPACT;
                    end
                    CMD_GET:
                    begin
                        if (pos_reg >= fill_reg)
                        begin
                            if (out_free)
                            begin
                                out_load        = 1'b1;
                                out_status_next = ST_BAD_POS;
                                state_next      = S_IDLE;
                            end
                        end
                        else
                        begin
                            cnt_next   = CW'(IW - 1);
                            state_next = S_SEARCH;
                        end
                    end
                    CMD_SET:
                    begin
                        if (out_free)
                        begin
                            out_load   = 1'b1;
                            state_next = S_IDLE;
                            if (pos_reg >= fill_reg)
                                out_status_next = ST_BAD_POS;
                            else
                                cell_ctrl.op = OP_WRITE;
                        end
                    end
                    CMD_FIND:
                    begin
                        cnt_next   = CW'(IW - 1);
                        state_next = S_SEARCH;
                    end
                    default:
                    begin
                        if (out_free)
                        begin
                            out_load   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_COMPACT:
            begin
                cell_ctrl.op = OP_SWAP;
                if (cnt_reg == '0)
                begin
                    cnt_next   = CW'(IW - 1);
                    state_next = S_SEARCH;
                end
                else
                    cnt_next = cnt_reg - CW'(1);
            end
            S_SEARCH:
            begin
                if (cnt_reg == '0)
                    state_next = S_FINISH;
                else
                    cnt_next = cnt_reg - CW'(1);
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    unique case (cmd_reg)
                        CMD_INS_SORT:
                        begin
                            cell_ctrl.op   = OP_INSERT;
                            cell_pos       = sort_at;
                            fill_next      = fill_reg + CW'(1);
                            out_index_next = sort_at;
                        end
                        CMD_REMOVE:
                        begin
                            fill_next      = new_fill;
                            out_index_next = fill_reg - new_fill;
                        end
                        CMD_GET:
                        begin
                            out_rdata_next = ITEM_BITS'(root_value);
                        end
                        default:
                        begin
                            if (root_found)
                                out_index_next = CW'(root_index);
                            else
                                out_status_next = ST_NOT_FOUND;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            cnt_reg   <= cnt_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg <= s_axis_tdata[CMD_BITS-1:0];
            pos_reg <= s_axis_tdata[CMD_BITS +: CW];
            val_reg <= VB'(s_axis_tdata[CMD_BITS+CW +: ITEM_BITS]);
        end
        if (out_load)
        begin
            out_status_reg <= out_status_next;
            out_index_reg  <= out_index_next;
            out_rdata_reg  <= out_rdata_next;
            out_count_reg  <= fill_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({(out_count_reg == '0), out_count_reg, out_rdata_reg,
                                   out_index_reg, out_status_reg});

endmodule

@@ sim/tb_ordered_sequence_table.sv @@
// Self-checking testbench for ordered_sequence_table: directed edge cases, then random
// command streams under four source/sink throttling profiles, checked against a predictor.
// Depends on ost_pkg and ordered_sequence_table.
module tb_ordered_sequence_table;
    import ost_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IN_BITS  = 48;
    localparam int OUT_BITS = 56;
    localparam int TBL_SIZE = DEPTH_DEF;
    localparam logic [CMD_BITS-1:0] CMD_UNUSED = 3'd7;

    typedef struct packed {
        status_t     status;
        logic [6:0]  idx;
        logic [31:0] rd;
        logic [6:0]  cnt;
        logic        empty;
    } table_reply_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // command, position, item_value
    logic [IN_BITS-1:0]  s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // status, result_index, read_value, entry_count, is_empty
    logic [OUT_BITS-1:0] m_axis_tdata;

    logic [31:0]  seq_vals [TBL_SIZE];
    int           seq_len = 0;
    table_reply_t pending_replies [$];
    int           mismatch_count = 0;
    int           src_idle_pct = 0;
    int           snk_stall_pct = 0;
    bit           growing = 1'b1;

    ordered_sequence_table u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);

    function automatic void open_slot(int at, logic [31:0] val);
        for (int i = seq_len; i > at; i--)
            seq_vals[i] = seq_vals[i - 1];
        seq_vals[at] = val;
        seq_len++;
    endfunction

    function automatic void close_slot(int at);
        for (int i = at; i + 1 < seq_len; i++)
            seq_vals[i] = seq_vals[i + 1];
        seq_len--;
    endfunction

    function automatic table_reply_t apply_command(logic [2:0] cmd, logic [6:0] pos,
                                                   logic [31:0] val);
        table_reply_t r;
        int           p;
        int           i;
        int           n;
        r = '0;
        r.status = ST_OK;
        p = int'(pos);
        n = 0;
        case (cmd)
            CMD_INS_AT:
                if (p > seq_len)
                    r.status = ST_BAD_POS;
                else if (seq_len >= TBL_SIZE)
                    r.status = ST_FULL;
                else
                begin
                    open_slot(p, val);
                    r.idx = pos;
                end
            CMD_INS_SORT:
                if (seq_len >= TBL_SIZE)
                    r.status = ST_FULL;
                else
                begin
                    i = 0;
                    while (i < seq_len && seq_vals[i] < val)
                        i++;
                    open_slot(i, val);
                    r.idx = 7'(i);
                end
            CMD_ERASE:
                if (p >= seq_len)
                    r.status = ST_BAD_POS;
                else
                    close_slot(p);
            CMD_REMOVE:
            begin
                i = 0;
                while (i < seq_len)
                begin
                    if (seq_vals[i] == val)
                    begin
                        close_slot(i);
                        n++;
                    end
                    else
                        i++;
                end
                r.idx = 7'(n);
            end
            CMD_GET:
                if (p >= seq_len)
                    r.status = ST_BAD_POS;
                else
                    r.rd = seq_vals[p];
            CMD_SET:
                if (p >= seq_len)
                    r.status = ST_BAD_POS;
                else
                    seq_vals[p] = val;
            CMD_FIND:
            begin
                r.status = ST_NOT_FOUND;
                for (i = 0; i < seq_len; i++)
                begin
                    if (seq_vals[i] == val)
                    begin
                        r.status = ST_OK;
                        r.idx = 7'(i);
                        break;
                    end
                end
            end
            default:
                r = '0;
        endcase
        r.cnt   = 7'(seq_len);
        r.empty = (seq_len == 0);
        return r;
    endfunction

    // predict on accepted commands, then check returned beats, in one edge
    always @(posedge clk)
    begin
        table_reply_t got;
        table_reply_t want;
        if (s_axis_tvalid && s_axis_tready)
            pending_replies.push_back(apply_command(s_axis_tdata[2:0], s_axis_tdata[9:3],
                                                    s_axis_tdata[41:10]));
        if (m_axis_tvalid && m_axis_tready)
        begin
            got.status = status_t'(m_axis_tdata[1:0]);
            got.idx    = m_axis_tdata[8:2];
            got.rd     = m_axis_tdata[40:9];
            got.cnt    = m_axis_tdata[47:41];
            got.empty  = m_axis_tdata[48];
            if (pending_replies.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected beat st=%0d idx=%0d rd=%h cnt=%0d empty=%0b",
                             $realtime, got.status, got.idx, got.rd, got.cnt, got.empty);
            end
            else
            begin
                want = pending_replies.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"%0t: exp st=%0d idx=%0d rd=%h cnt=%0d empty=%0b",
                                  " got st=%0d idx=%0d rd=%h cnt=%0d empty=%0b"},
                                 $realtime, want.status, want.idx, want.rd, want.cnt,
                                 want.empty, got.status, got.idx, got.rd, got.cnt,
                                 got.empty);
                end
            end
        end
    end

    task automatic send_beat(input logic [2:0] cmd, input logic [6:0] pos,
                             input logic [31:0] val);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, val, pos, cmd};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    function automatic logic [2:0] pick_command();
        int r;
        r = $urandom_range(99);
        if (growing)
        begin
            if (r < 45) return CMD_INS_AT;
            if (r < 75) return CMD_INS_SORT;
            if (r < 80) return CMD_ERASE;
            if (r < 83) return CMD_REMOVE;
            if (r < 89) return CMD_GET;
            if (r < 94) return CMD_SET;
            if (r < 99) return CMD_FIND;
        end
        else
        begin
            if (r < 8)  return CMD_INS_AT;
            if (r < 14) return CMD_INS_SORT;
            if (r < 50) return CMD_ERASE;
            if (r < 65) return CMD_REMOVE;
            if (r < 76) return CMD_GET;
            if (r < 86) return CMD_SET;
            if (r < 99) return CMD_FIND;
        end
        return CMD_UNUSED;
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 32'($urandom_range(15));
        if (r < 60)
            return 32'hFFFF_FFFF - 32'($urandom_range(3));
        if (r < 70 && seq_len > 0)
            return seq_vals[$urandom_range(seq_len - 1)];
        return $urandom();
    endfunction

    function automatic logic [6:0] pick_position();
        int r;
        int p;
        r = $urandom_range(99);
        if (r < 80)
            p = $urandom_range(seq_len);
        else if (r < 92)
            p = seq_len + $urandom_range(1);
        else
            p = $urandom_range(127);
        return 7'(p);
    endfunction

    task automatic test_empty_table();
        send_beat(CMD_GET, 7'd0, 32'd0);
        send_beat(CMD_ERASE, 7'd0, 32'd0);
        send_beat(CMD_SET, 7'd0, 32'h1234_5678);
        send_beat(CMD_FIND, 7'd0, 32'd0);
        send_beat(CMD_REMOVE, 7'd0, 32'd0);
        send_beat(CMD_INS_AT, 7'd1, 32'd9);
        send_beat(CMD_UNUSED, 7'd127, 32'hFFFF_FFFF);
    endtask

    task automatic test_edge_commands();
        send_beat(CMD_INS_AT, 7'd0, 32'hFFFF_FFFF);
        send_beat(CMD_INS_AT, 7'd1, 32'd0);
        send_beat(CMD_INS_SORT, 7'd0, 32'd5);
        send_beat(CMD_INS_SORT, 7'd0, 32'd0);
        send_beat(CMD_INS_SORT, 7'd0, 32'hFFFF_FFFF);
        send_beat(CMD_INS_AT, 7'd127, 32'd3);
        send_beat(CMD_GET, 7'd127, 32'd0);
        send_beat(CMD_GET, 7'd5, 32'd0);
        send_beat(CMD_GET, 7'd4, 32'd0);
        send_beat(CMD_SET, 7'd0, 32'd5);
        send_beat(CMD_FIND, 7'd0, 32'd5);
        send_beat(CMD_FIND, 7'd0, 32'd77);
        send_beat(CMD_REMOVE, 7'd0, 32'd5);
        send_beat(CMD_ERASE, 7'd127, 32'd0);
        send_beat(CMD_ERASE, 7'd2, 32'd0);
        send_beat(CMD_UNUSED, 7'd0, 32'd1);
        send_beat(CMD_GET, 7'd1, 32'd0);
        send_beat(CMD_REMOVE, 7'd0, 32'hFFFF_FFFF);
    endtask

    task automatic run_random_phase(int src_pct, int snk_pct, int beats);
        logic [2:0] cmd;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        for (int n = 0; n < beats; n++)
        begin
            if (growing && seq_len == TBL_SIZE && $urandom_range(7) == 0)
                growing = 1'b0;
            else if (!growing && seq_len == 0)
                growing = 1'b1;
            cmd = pick_command();
            send_beat(cmd, pick_position(), pick_value());
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_empty_table();
        test_edge_commands();
        run_random_phase(0, 0, 165);
        run_random_phase(46, 0, 165);
        run_random_phase(0, 46, 165);
        run_random_phase(13, 13, 165);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (TBL_SIZE + 16) @(posedge clk);
        if (mismatch_count == 0)
            $display("ordered_sequence_table: match");
        else
            $display("ordered_sequence_table: mismatch");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("ordered_sequence_table: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/ost_pkg.sv
rtl/core/ost_cell.sv
rtl/core/ost_pick_tree.sv
rtl/core/ordered_sequence_table.sv
sim/tb_ordered_sequence_table.sv
